// ===== hdl/tle_pkg.sv =====
// Package for the terminal line editor: command, result and state types,
// register indexes and reset values. No dependencies.
package tle_pkg;

	localparam int LINE_DEPTH_DEF = 64;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int LEN_W      = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WERASE_CHAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KILL_CHAR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EOF_CHAR    = 3'd4;

	localparam logic [LEN_W-1:0] RST_LINE_LENGTH = 7'd40;
	localparam logic [7:0]       RST_ERASE_CHAR  = 8'd127;
	localparam logic [7:0]       RST_WERASE_CHAR = 8'd23;
	localparam logic [7:0]       RST_KILL_CHAR   = 8'd21;
	localparam logic [7:0]       RST_EOF_CHAR    = 8'd4;

	localparam logic [7:0] SPACE_BYTE = 8'h20;

	typedef enum logic [1:0] {
		ACT_ECHO    = 2'd0,
		ACT_ERASE   = 2'd1,
		ACT_ECHO_NL = 2'd2,
		ACT_END     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CMD_STORE,
		CMD_WERASE,
		CMD_KILL,
		CMD_ERASE,
		CMD_EOF
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] echo_char;
		logic       last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KILL,
		ST_WORD
	} back_state_t;

	typedef enum logic [1:0] {
		PH_TRAIL,
		PH_WORD,
		PH_LEAD
	} word_phase_t;

	typedef struct packed {
		logic  valid;
		cmd_t  cmd;
	} cmd_chan_t;

endpackage

// ===== hdl/terminal_line_editor.sv =====
// Top level of the terminal line editor: configuration registers, front end,
// back end and result queue. Depends on tle_pkg, tle_front, tle_back, tle_fifo.
//
// Typed bytes enter through a queue-like port: a request is taken when push is
// high and full is low. Results leave the same way: while empty is low the
// oldest result sits on action, echo_char and last, and it is taken when pop
// is high. Each result is one terminal action; last marks the final result of
// an input byte, and bytes that cause nothing (erase on an empty line, end of
// file on a non-empty line) give no result at all.
// The front end classifies a byte in the cycle it is taken and parks it in a
// two-entry command queue; the back end executes it against the line store.
// A stored byte, a single erase or an end of file is handled by the back end
// straight from its idle state. A kill gives one erase result per removed
// character, the final one marked last; a word erase walks back over the
// line one character at a time through the one read port of the line store.
// When the receiver stalls, the two-entry result queue fills, the back end
// holds its place, and the command queue then raises full.
// Reset empties both queues, sets the cursor to zero and loads the default
// control bytes; the line store itself is not cleared. Configuration writes
// land at once and must only be made while the block is idle.
module terminal_line_editor import tle_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            in_byte,
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            action,
	output logic [7:0]            echo_char,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [LEN_W-1:0] line_length_q;
	logic [7:0]       erase_char_q;
	logic [7:0]       werase_char_q;
	logic [7:0]       kill_char_q;
	logic [7:0]       eof_char_q;

	cmd_chan_t cmd_chan;
	logic      cmd_pop;
	logic      res_push;
	result_t   res;
	logic      res_full;
	result_t   res_out;
	logic      res_valid;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= RST_LINE_LENGTH;
			erase_char_q  <= RST_ERASE_CHAR;
			werase_char_q <= RST_WERASE_CHAR;
			kill_char_q   <= RST_KILL_CHAR;
			eof_char_q    <= RST_EOF_CHAR;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_LINE_LENGTH: line_length_q <= cfg_wdata[LEN_W-1:0];
				CFG_ERASE_CHAR:  erase_char_q  <= cfg_wdata;
				CFG_WERASE_CHAR: werase_char_q <= cfg_wdata;
				CFG_KILL_CHAR:   kill_char_q   <= cfg_wdata;
				CFG_EOF_CHAR:    eof_char_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	tle_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.in_byte        (in_byte),
		.full           (full),
		.erase_char     (erase_char_q),
		.word_erase_char(werase_char_q),
		.kill_char      (kill_char_q),
		.eof_char       (eof_char_q),
		.cmd_chan       (cmd_chan),
		.cmd_pop        (cmd_pop)
	);

	tle_back #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_length(line_length_q),
		.cmd_chan   (cmd_chan),
		.cmd_pop    (cmd_pop),
		.res_push   (res_push),
		.res        (res),
		.res_full   (res_full)
	);

	// Result queue decouples the back end from a stalling receiver.
	tle_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.valid  (res_valid)
	);

	assign empty     = !res_valid;
	assign action    = res_out.action;
	assign echo_char = res_out.echo_char;
	assign last      = res_out.last;

	// The back end must never push into a full result queue.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result pushed into a full queue");

	// Commands are only taken when one is waiting.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_chan.valid)
		else $error("command popped from an empty queue");

	// An end of file result always closes its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.action == ACT_END) |-> res.last)
		else $error("end result not marked last");

endmodule

// ===== hdl/tle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// A read of the address being written returns the new data. No dependencies.
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/tle_fifo.sv =====
// Small synchronous FIFO in flip-flops used for the command and result queues.
// DEPTH must be a power of two. No dependencies.
module tle_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             valid
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNTW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

// ===== hdl/tle_front.sv =====
// Front end of the line editor: classifies each typed byte against the control
// bytes and queues the resulting command. Depends on tle_pkg and tle_fifo.
module tle_front import tle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_byte,
	output logic       full,
	input  logic [7:0] erase_char,
	input  logic [7:0] word_erase_char,
	input  logic [7:0] kill_char,
	input  logic [7:0] eof_char,
	output cmd_chan_t  cmd_chan,
	input  logic       cmd_pop
);

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_valid;

	// The first matching control byte wins.
	always_comb begin
		cmd_in.data = in_byte;
		priority if (in_byte == word_erase_char) begin
			cmd_in.op = CMD_WERASE;
		end else if (in_byte == kill_char) begin
			cmd_in.op = CMD_KILL;
		end else if (in_byte == erase_char) begin
			cmd_in.op = CMD_ERASE;
		end else if (in_byte == eof_char) begin
			cmd_in.op = CMD_EOF;
		end else begin
			cmd_in.op = CMD_STORE;
		end
	end

	tle_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cmd_in),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.valid  (cmd_valid)
	);

	assign cmd_chan.valid = cmd_valid;
	assign cmd_chan.cmd   = cmd_out;

endmodule

// ===== hdl/tle_back.sv =====
// Back end of the line editor: owns the line store and cursor, carries out
// queued commands and emits results. Depends on tle_pkg and tle_ram.
module tle_back import tle_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LEN_W-1:0] line_length,
	input  cmd_chan_t        cmd_chan,
	output logic             cmd_pop,
	output logic             res_push,
	output result_t          res,
	input  logic             res_full
);

	localparam int CW = $clog2(LINE_DEPTH);
	localparam int LW = ($clog2(LINE_DEPTH + 1) > LEN_W) ? $clog2(LINE_DEPTH + 1) : LEN_W;

	back_state_t state_q, state_d;
	word_phase_t phase_q, phase_d;
	logic        pend_q, pend_d;
	logic [CW-1:0] cursor_q, cursor_d;

	logic [LW-1:0] len_raw;
	logic [LW-1:0] len_eff;
	logic [CW:0]   cur_inc;
	logic          wrap;
	logic          cur_zero;
	logic          cur_one;
	logic          ram_we;
	logic [CW-1:0] raddr;
	logic [7:0]    rd_byte;
	logic          is_space;
	logic          take;

	// Zero acts as one, anything above the store depth acts as the depth.
	assign len_raw = LW'(line_length);
	always_comb begin
		if (len_raw == '0) begin
			len_eff = LW'(1);
		end else if (len_raw > LW'(LINE_DEPTH)) begin
			len_eff = LW'(LINE_DEPTH);
		end else begin
			len_eff = len_raw;
		end
	end

	assign cur_inc  = {1'b0, cursor_q} + (CW + 1)'(1);
	assign wrap     = (LW'(cur_inc) >= len_eff);
	assign cur_zero = (cursor_q == '0);
	assign cur_one  = (cursor_q == CW'(1));
	assign is_space = (rd_byte == SPACE_BYTE);
	assign take     = (phase_q == PH_WORD) ? !is_space : is_space;

	// The read port follows the character left of the next cursor (address zero
	// when that cursor is zero), so the word erase walk sees it in the next cycle with no extra wait.
	assign raddr = (cursor_d == '0) ? '0 : cursor_d - CW'(1);

	tle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cursor_q),
		.wdata(cmd_chan.cmd.data),
		.raddr(raddr),
		.rdata(rd_byte)
	);

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		pend_d   = pend_q;
		cursor_d = cursor_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		ram_we   = 1'b0;
		res.action    = ACT_ERASE;
		res.echo_char = '0;
		res.last      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_chan.valid) begin
					unique case (cmd_chan.cmd.op)
						CMD_STORE: begin
							if (!res_full) begin
								cmd_pop       = 1'b1;
								ram_we        = 1'b1;
								res_push      = 1'b1;
								res.action    = wrap ? ACT_ECHO_NL : ACT_ECHO;
								res.echo_char = cmd_chan.cmd.data;
								cursor_d      = wrap ? '0 : cur_inc[CW-1:0];
							end
						end
						CMD_ERASE: begin
							if (cur_zero) begin
								cmd_pop = 1'b1;
							end else if (!res_full) begin
								cmd_pop  = 1'b1;
								res_push = 1'b1;
								cursor_d = cursor_q - CW'(1);
							end
						end
						CMD_EOF: begin
							if (!cur_zero) begin
								cmd_pop = 1'b1;
							end else if (!res_full) begin
								cmd_pop    = 1'b1;
								res_push   = 1'b1;
								res.action = ACT_END;
							end
						end
						CMD_KILL: begin
							cmd_pop = 1'b1;
							if (!cur_zero) begin
								state_d = ST_KILL;
							end
						end
						CMD_WERASE: begin
							cmd_pop = 1'b1;
							if (!cur_zero) begin
								state_d = ST_WORD;
								phase_d = PH_TRAIL;
								pend_d  = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_KILL: begin
				if (!res_full) begin
					res_push = 1'b1;
					res.last = cur_one;
					cursor_d = cursor_q - CW'(1);
					if (cur_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_WORD: begin
				// Each removal is reported only when the next one is made, so that the final one
				// can be marked last once the walk stops.
				if (!cur_zero && take) begin
					if (!pend_q) begin
						pend_d   = 1'b1;
						cursor_d = cursor_q - CW'(1);
					end else if (!res_full) begin
						res_push = 1'b1;
						res.last = 1'b0;
						cursor_d = cursor_q - CW'(1);
					end
				end else if (!cur_zero && phase_q != PH_LEAD) begin
					phase_d = (phase_q == PH_TRAIL) ? PH_WORD : PH_LEAD;
				end else if (!res_full) begin
					res_push = 1'b1;
					pend_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_TRAIL;
			pend_q   <= 1'b0;
			cursor_q <= '0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			pend_q   <= pend_d;
			cursor_q <= cursor_d;
		end
	end

endmodule
